[design/nch_pkg.sv]
// ============================================================================
// nch_pkg
// Shared types, codes and defaults for the nearest centroid histogram block.
// ============================================================================
`default_nettype none

package nch_pkg;

    // Parameter defaults
    localparam int DEF_MAX_DIMS      = 128;
    localparam int DEF_MAX_CENTROIDS = 256;
    localparam int DEF_COUNT_BITS    = 16;

    // Fixed field widths
    localparam int LABEL_W  = 8;
    localparam int DIST_W   = 39;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Request function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_DESC  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // Response kinds
    localparam logic KIND_LABEL = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTROIDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  centroid_index;
        logic [6:0]  dim_index;
        logic [15:0] centroid_value;
        logic [7:0]  desc_value;
        logic        desc_last;
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        label;
        logic [DIST_W-1:0] distance;
        logic [15:0]       bin_count;
    } rsp_t;

    // Tag that travels with each element through the distance pipeline
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [LABEL_W-1:0] idx;
    } tag_t;

endpackage

`default_nettype wire

[design/nch_ram.sv]
// ============================================================================
// nch_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module nch_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/nch_dist.sv]
// ============================================================================
// nch_dist
// Distance pipeline: difference, square, saturating accumulate, best search.
// ============================================================================
`default_nettype none

module nch_dist
    import nch_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tag_t               issue_tag,
    input  wire logic [7:0]         desc_q,
    input  wire logic [15:0]        cent_q,
    output      logic               busy,
    output      logic [LABEL_W-1:0] best_idx,
    output      logic [DIST_W-1:0]  best_dist
);

    tag_t                rd_tag_reg;
    tag_t                df_tag_reg;
    tag_t                sq_tag_reg;
    logic signed [16:0]  diff_reg;
    logic [31:0]         sq_reg;
    logic [DIST_W-1:0]   acc_reg;
    logic                fin_valid_reg;
    logic [DIST_W-1:0]   fin_dist_reg;
    logic [LABEL_W-1:0]  fin_idx_reg;
    logic [LABEL_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0]   best_dist_reg;

    logic signed [16:0]  diff_next;
    logic signed [33:0]  prod;
    logic [DIST_W:0]     acc_sum;
    logic [DIST_W-1:0]   acc_next;

    // descriptor element scaled to 8.8
    assign diff_next = $signed({1'b0, desc_q, 8'd0}) - $signed({1'b0, cent_q});
    assign prod      = diff_reg * diff_reg;
    assign acc_sum   = (sq_tag_reg.first ? '0 : {1'b0, acc_reg}) + (DIST_W + 1)'(sq_reg);
    assign acc_next  = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg    <= '0;
            df_tag_reg    <= '0;
            sq_tag_reg    <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            rd_tag_reg    <= issue_tag;
            df_tag_reg    <= rd_tag_reg;
            sq_tag_reg    <= df_tag_reg;
            fin_valid_reg <= sq_tag_reg.valid && sq_tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg   <= prod[31:0];
        if (sq_tag_reg.valid)
        begin
            acc_reg <= acc_next;
            if (sq_tag_reg.last)
            begin
                fin_dist_reg <= acc_next;
                fin_idx_reg  <= sq_tag_reg.idx;
            end
        end
        // strict less-than keeps the lowest index on ties
        if (fin_valid_reg && ((fin_idx_reg == '0) || (fin_dist_reg < best_dist_reg)))
        begin
            best_dist_reg <= fin_dist_reg;
            best_idx_reg  <= fin_idx_reg;
        end
    end

    assign busy      = rd_tag_reg.valid || df_tag_reg.valid || sq_tag_reg.valid
                       || fin_valid_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

`default_nettype wire

[design/nearest_centroid_histogram.sv]
// ============================================================================
// nearest_centroid_histogram
// Vector quantization of descriptors against a centroid table, with a
// saturating histogram of the assigned labels.
// ============================================================================
// A request loads a centroid element, delivers a descriptor element, reads a
// histogram bin or clears the histogram. Loads, clears and descriptor
// elements not marked last give no response. A bin read answers with kind
// set, the bin index in label, a zero distance and the count. A descriptor
// element marked last starts the search: one squared difference is
// accumulated per cycle, reading the centroid store and the descriptor
// buffer once each, over N*D elements (N centroids in use, D dimensions in
// use, both clamped), followed by pipeline drain and histogram update. The
// label response carries the count of the bin after its increment. A
// response waits in an output register, and requests without a response are
// still taken while it waits.
// ============================================================================
`default_nettype none

module nearest_centroid_histogram
    import nch_pkg::*;
#(
    parameter int MAX_DIMS      = DEF_MAX_DIMS,
    parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 req_valid,
    output      logic                 req_stall,
    input  wire req_t                 req,
    output      logic                 rsp_valid,
    input  wire logic                 rsp_stall,
    output      rsp_t                 rsp
);

    // Only 256 labels can be named, so stores stop there.
    localparam int CENT_LIM   = (MAX_CENTROIDS < 256) ? MAX_CENTROIDS : 256;
    localparam int CS_DEPTH   = CENT_LIM * MAX_DIMS;
    localparam int CS_AW      = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;
    localparam int DESC_AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int HIST_AW    = (CENT_LIM > 1) ? $clog2(CENT_LIM) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_HREAD  = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_BIN    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [8:0]          cents_reg;
    logic [7:0]          dims_reg;
    logic [7:0]          d_reg, d_next;
    logic [7:0]          c_reg, c_next;
    logic [CS_AW-1:0]    base_reg, base_next;
    logic [7:0]          bin_idx_reg;
    logic                bin_ok_reg;
    logic [CENT_LIM-1:0] hist_vld_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [8:0]          eff_n;
    logic [7:0]          eff_d;
    logic                accept;
    logic                slot_free;
    logic                last_dim;
    logic                last_cent;

    // memory ports
    logic                cs_we;
    logic [CS_AW-1:0]    cs_waddr;
    logic [CS_AW-1:0]    cs_raddr;
    logic [15:0]         cs_q;
    logic                db_we;
    logic [DESC_AW-1:0]  db_raddr;
    logic [7:0]          db_q;
    logic                search_re;
    logic                h_we;
    logic                h_re;
    logic [HIST_AW-1:0]  h_raddr;
    logic [HIST_AW-1:0]  best_a;
    logic [HIST_AW-1:0]  bin_a;
    logic [COUNT_BITS-1:0] h_q;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [COUNT_BITS-1:0] bin_cnt;

    tag_t                issue_tag;
    logic                dist_busy;
    logic [LABEL_W-1:0]  best_idx;
    logic [DIST_W-1:0]   best_dist;

    // ---- configuration, clamped to the supported range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cents_reg <= 9'd256;
            dims_reg  <= 8'd128;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTROIDS: cents_reg <= cfg_data;
                REG_DIMS:      dims_reg  <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        eff_n = cents_reg;
        if (cents_reg == '0)
        begin
            eff_n = 9'd1;
        end
        else if (32'(cents_reg) > CENT_LIM)
        begin
            eff_n = 9'(CENT_LIM);
        end
        eff_d = dims_reg;
        if (dims_reg == '0)
        begin
            eff_d = 8'd1;
        end
        else if (32'(dims_reg) > MAX_DIMS)
        begin
            eff_d = 8'(MAX_DIMS);
        end
    end

    // ---- handshake
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // ---- search sequencing: dimensions inner, centroids outer
    assign last_dim  = (d_reg == eff_d - 8'd1);
    assign last_cent = ({1'b0, c_reg} == eff_n - 9'd1);
    assign search_re = (state_reg == ST_SEARCH);

    always_comb
    begin
        issue_tag       = '0;
        issue_tag.valid = search_re;
        issue_tag.first = (d_reg == '0);
        issue_tag.last  = last_dim;
        issue_tag.idx   = c_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        c_next     = c_reg;
        base_next  = base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_DESC:
                        begin
                            if (req.desc_last)
                            begin
                                state_next = ST_SEARCH;
                                d_next     = '0;
                                c_next     = '0;
                                base_next  = '0;
                            end
                        end
                        FUNC_READ: state_next = ST_BIN;
                        default:   ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (last_dim)
                begin
                    d_next    = '0;
                    c_next    = c_reg + 8'd1;
                    base_next = base_reg + CS_AW'(MAX_DIMS);
                    if (last_cent)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    d_next = d_reg + 8'd1;
                end
            end
            ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = ST_HREAD;
                end
            end
            ST_HREAD: state_next = ST_UPD;
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            d_reg     <= '0;
            c_reg     <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            d_reg     <= d_next;
            c_reg     <= c_next;
            base_reg  <= base_next;
        end
    end

    // ---- centroid store
    assign cs_we    = accept && (req.func == FUNC_LOAD)
                      && (32'(req.centroid_index) < CENT_LIM)
                      && (32'(req.dim_index) < MAX_DIMS);
    assign cs_waddr = CS_AW'(req.centroid_index) * CS_AW'(MAX_DIMS)
                      + CS_AW'(req.dim_index);
    assign cs_raddr = base_reg + CS_AW'(d_reg);

    nch_ram #(
        .WIDTH  (16),
        .DEPTH  (CS_DEPTH),
        .ADDR_W (CS_AW)
    ) u_cstore (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (req.centroid_value),
        .re    (search_re),
        .raddr (cs_raddr),
        .rdata (cs_q)
    );

    // ---- descriptor buffer; the last element lands before the first read
    assign db_we    = accept && (req.func == FUNC_DESC) && (32'(req.dim_index) < MAX_DIMS);
    assign db_raddr = DESC_AW'(d_reg);

    nch_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_DIMS),
        .ADDR_W (DESC_AW)
    ) u_dbuf (
        .clk   (clk),
        .we    (db_we),
        .waddr (DESC_AW'(req.dim_index)),
        .wdata (req.desc_value),
        .re    (search_re),
        .raddr (db_raddr),
        .rdata (db_q)
    );

    // ---- distance pipeline
    nch_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .desc_q    (db_q),
        .cent_q    (cs_q),
        .busy      (dist_busy),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    // ---- histogram: RAM plus one valid bit per bin, unset bins read zero.
    // Update is read in HREAD, modified and written in UPD; the FSM
    // serializes requests, so a later read always sees the write.
    assign best_a  = HIST_AW'(best_idx);
    assign bin_a   = HIST_AW'(req.centroid_index);
    assign h_re    = (accept && (req.func == FUNC_READ)) || (state_reg == ST_HREAD);
    assign h_raddr = (state_reg == ST_HREAD) ? best_a : bin_a;
    assign h_we    = (state_reg == ST_UPD) && slot_free;
    assign cur_cnt = hist_vld_reg[best_a] ? h_q : '0;
    assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
    assign bin_cnt = (bin_ok_reg && hist_vld_reg[HIST_AW'(bin_idx_reg)]) ? h_q : '0;

    nch_ram #(
        .WIDTH  (COUNT_BITS),
        .DEPTH  (CENT_LIM),
        .ADDR_W (HIST_AW)
    ) u_hist (
        .clk   (clk),
        .we    (h_we),
        .waddr (best_a),
        .wdata (inc_cnt),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
        end
        else if (accept && (req.func == FUNC_CLEAR))
        begin
            hist_vld_reg <= '0;
        end
        else if (h_we)
        begin
            hist_vld_reg[best_a] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.func == FUNC_READ))
        begin
            bin_idx_reg <= req.centroid_index;
            bin_ok_reg  <= (32'(req.centroid_index) < CENT_LIM);
        end
    end

    // ---- response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (((state_reg == ST_UPD) || (state_reg == ST_BIN)) && slot_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_UPD) && slot_free)
        begin
            rsp_reg.kind      <= KIND_LABEL;
            rsp_reg.label     <= best_idx;
            rsp_reg.distance  <= best_dist;
            rsp_reg.bin_count <= 16'(inc_cnt);
        end
        else if ((state_reg == ST_BIN) && slot_free)
        begin
            rsp_reg.kind      <= KIND_BIN;
            rsp_reg.label     <= bin_idx_reg;
            rsp_reg.distance  <= '0;
            rsp_reg.bin_count <= 16'(bin_cnt);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[design/nch_checker.sv]
// ============================================================================
// nch_checker
// Port-level checks for the nearest centroid histogram, bound to the top.
// ============================================================================
`default_nettype none

module nch_checker
    import nch_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // bin read responses carry no distance
    a_bin_dist: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_BIN) |-> (rsp.distance == '0))
        else $error("bin read response with nonzero distance");

    // a request that owes a response keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall
        && ((req.func == FUNC_READ) || ((req.func == FUNC_DESC) && req.desc_last))
        |=> req_stall)
        else $error("block took a request while a response was owed");

    // loads never stall the channel
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.func == FUNC_LOAD) |=> !req_stall)
        else $error("stall after a centroid load");

endmodule

bind nearest_centroid_histogram nch_checker u_nch_checker (.*);

`default_nettype wire
